// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file of this project.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or plain property, disabled while reset is held.
`define FNVCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define FNVCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/fnvcd_pkg.sv -----
// ----------------------------------------------------------------------------
// FNV-1a commitment digest package
// Constants, status types, the hash fold and the count terms used by the digest modules.
// ----------------------------------------------------------------------------
package fnvcd_pkg;

  localparam int HashW = 64;
  localparam int ByteW = 8;
  localparam int CountPortW = 16;
  localparam int WordIdxW = 2;
  localparam int CountBitsDefault = 16;
  localparam int CountStride = 13;

  localparam logic [HashW-1:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [WordIdxW-1:0] LastWordIdx = 2'd3;

  // The prime 0x100000001b3 is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0.
  localparam int PrimeSh0 = 40;
  localparam int PrimeSh1 = 8;
  localparam int PrimeSh2 = 7;
  localparam int PrimeSh3 = 5;
  localparam int PrimeSh4 = 4;
  localparam int PrimeSh5 = 1;

  // Queue occupancy seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Only the low count bits that both the port and the parameter carry are used.
  function automatic int cnt_width(input int count_bits);
    return (count_bits < CountPortW) ? count_bits : CountPortW;
  endfunction

  // One FNV-1a step: xor in the byte, multiply by the prime modulo 2^64.
  function automatic logic [HashW-1:0] fnv_fold(input logic [HashW-1:0] h,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] x;
    x = h ^ {{(HashW-ByteW){1'b0}}, b};
    return (x << PrimeSh0) + (x << PrimeSh1) + (x << PrimeSh2) + (x << PrimeSh3)
         + (x << PrimeSh4) + (x << PrimeSh5) + x;
  endfunction

  // Count term of digest word k: the count shifted left by 13 * k.
  function automatic logic [HashW-1:0] count_term(input logic [HashW-1:0] n,
                                                  input logic [WordIdxW-1:0] k);
    logic [HashW-1:0] t;
    case (k)
      2'd0: begin
        t = n;
      end
      2'd1: begin
        t = n << CountStride;
      end
      2'd2: begin
        t = n << (2 * CountStride);
      end
      default: begin
        t = n << (3 * CountStride);
      end
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/fnvcd_front.sv -----
// ----------------------------------------------------------------------------
// FNV-1a front end
// Folds each accepted byte into the running hash and queues finished messages.
// ----------------------------------------------------------------------------
module fnvcd_front import fnvcd_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ByteW-1:0]      data_byte_i,
  input  logic                  last_byte_i,
  input  logic [CountPortW-1:0] element_count_i,
  input  q_status_t             q_status_i,
  output logic                  push_o,
  output logic [HashW+cnt_width(COUNT_BITS)-1:0] push_data_o
);

  localparam int CntW = cnt_width(COUNT_BITS);

  logic [HashW-1:0] hash_q, hash_d;
  logic [HashW-1:0] folded;
  logic             accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign folded     = fnv_fold(hash_q, data_byte_i);

  assign push_o      = accept && last_byte_i;
  assign push_data_o = {folded, element_count_i[CntW-1:0]};

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = last_byte_i ? FnvBasis : folded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// ----- rtl/fnvcd_queue.sv -----
// ----------------------------------------------------------------------------
// FNV-1a message queue
// Two-entry FIFO of finished hashes with their element counts.
// ----------------------------------------------------------------------------
module fnvcd_queue import fnvcd_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  logic [HashW+cnt_width(COUNT_BITS)-1:0] push_data_i,
  input  logic      pop_i,
  output logic [HashW+cnt_width(COUNT_BITS)-1:0] head_o,
  output q_status_t status_o
);

  localparam int EntryW = HashW + cnt_width(COUNT_BITS);

  logic [1:0][EntryW-1:0] mem_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign head_o             = mem_q[rd_ptr_q];
  assign status_o.full      = (cnt_q == 2'd2);
  assign status_o.not_empty = (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ----- rtl/fnvcd_back.sv -----
// ----------------------------------------------------------------------------
// FNV-1a back end
// Expands each queued hash into four digest words through an output register.
// ----------------------------------------------------------------------------
module fnvcd_back import fnvcd_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [HashW+cnt_width(COUNT_BITS)-1:0] head_i,
  input  q_status_t           q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HashW-1:0]    digest_word_o,
  output logic [WordIdxW-1:0] word_index_o,
  output logic                last_word_o
);

  localparam int CntW = cnt_width(COUNT_BITS);

  logic                valid_q, valid_d;
  logic [HashW-1:0]    word_q;
  logic [WordIdxW-1:0] idx_q;
  logic                last_q;
  logic [WordIdxW-1:0] k_q, k_d;
  logic                load;
  logic [HashW-1:0]    hash;
  logic [HashW-1:0]    count;

  assign hash  = head_i[HashW+CntW-1:CntW];
  assign count = {{(HashW-CntW){1'b0}}, head_i[CntW-1:0]};

  // A new word enters the output register when the queue is not empty and the register is empty or being drained.
  assign load  = q_status_i.not_empty && (!valid_q || !out_stall_i);
  assign pop_o = load && (k_q == LastWordIdx);

  always_comb begin
    valid_d = valid_q && out_stall_i;
    k_d     = k_q;
    if (load) begin
      valid_d = 1'b1;
      k_d     = k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= hash ^ count_term(count, k_q);
      idx_q  <= k_q;
      last_q <= (k_q == LastWordIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      valid_q <= valid_d;
      k_q     <= k_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign digest_word_o = word_q;
  assign word_index_o  = idx_q;
  assign last_word_o   = last_q;

endmodule

// ----- rtl/fnv1a64_commitment_digest_top.sv -----
// ----------------------------------------------------------------------------
// FNV-1a 64-bit commitment digest
// Hashes a byte stream and emits four count-mixed digest words per message.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle in unless in_stall_o; four digest words per message
// out, one per cycle unless out_stall_i. A finished hash goes into a queue entry
// as its last byte is accepted; its first word then enters the back output register.
// The input stalls only while both queue entries hold messages not yet fully emitted.
// Reset: asynchronous, active low; the running hash returns to the offset basis,
// the queue empties and no digest word is valid.
module fnv1a64_commitment_digest_top import fnvcd_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ByteW-1:0]      data_byte_i,
  input  logic                  last_byte_i,
  input  logic [CountPortW-1:0] element_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [HashW-1:0]      digest_word_o,
  output logic [WordIdxW-1:0]   word_index_o,
  output logic                  last_word_o
);

  // Each queue entry carries the finished hash and the usable count bits.
  localparam int EntryW = HashW + cnt_width(COUNT_BITS);

  q_status_t         q_status;
  logic              push;
  logic              pop;
  logic [EntryW-1:0] push_data;
  logic [EntryW-1:0] head;

  // The front folds one byte per cycle while not stalled, with shifts and adds of
  // the sparse prime. On the last byte it pushes the final hash and count as one
  // request and restarts at the offset basis, so the next message can follow at once.
  fnvcd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .element_count_i(element_count_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // The queue lets the front keep hashing while the back is still emitting
  // the four words of an earlier message or is held by the sink.
  fnvcd_queue #(
    .COUNT_BITS(COUNT_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // The back walks word index 0 to 3 over the head entry and pops it as
  // the last word is loaded into the output register.
  fnvcd_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

endmodule

// ----- rtl/fnvcd_checker.sv -----
// ----------------------------------------------------------------------------
// FNV-1a digest port checker
// Watches the top-level ports for word ordering and output hold behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fnvcd_checker import fnvcd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [HashW-1:0]      digest_word_o,
  input logic [WordIdxW-1:0]   word_index_o,
  input logic                  last_word_o
);

  logic out_take;
  assign out_take = out_valid_o && !out_stall_i;

  `FNVCD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(digest_word_o) && $stable(word_index_o) && $stable(last_word_o), "stalled digest word changed")
  `FNVCD_ASSERT(a_last_flag, !out_valid_o || (last_word_o == (word_index_o == LastWordIdx)), "last word flag does not match word index")
  `FNVCD_ASSERT_NEXT(a_words_burst, out_take && !last_word_o, out_valid_o && (word_index_o == $past(word_index_o) + 2'd1), "digest words not emitted in order without gaps")
  `FNVCD_ASSERT_NEXT(a_new_digest, out_take && last_word_o, !out_valid_o || (word_index_o == '0), "new digest does not start at word zero")

endmodule

bind fnv1a64_commitment_digest_top fnvcd_checker u_fnvcd_checker (.*);
